// ----- design/obm_pkg.sv -----
package obm_pkg;

  localparam int unsigned OBM_BOOK_DEPTH = 64;
  localparam int unsigned PRICE_W = 16;

  typedef logic [PRICE_W-1:0] price_t;
  typedef logic [1:0] status_t;

  localparam status_t STATUS_FILL = 2'd0;
  localparam status_t STATUS_REST = 2'd1;
  localparam status_t STATUS_DROP = 2'd2;

  localparam logic OP_BUY  = 1'b0;
  localparam logic OP_SELL = 1'b1;

  typedef struct packed {
    logic   ins;
    logic   pop;
    price_t price;
  } book_cmd_t;

  typedef struct packed {
    price_t head;
    price_t head_next;
    logic   empty;
    logic   empty_next;
    logic   full;
  } book_stat_t;

endpackage

// ----- design/price_priority_order_book_match.sv -----
// A result is registered and appears in the cycle after its order transfers.
// Throughput: one order per cycle unless the input stalls; both books update in the same cycle
// through a row of compare-and-shift cells per book.
// Input stalls only while a result is held by a stalled output.
// Reset (rst, synchronous): both books empty, no result pending.
module price_priority_order_book_match #(
  parameter int unsigned BOOK_DEPTH = obm_pkg::OBM_BOOK_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              op,
  input  obm_pkg::price_t   limit_price,
  output logic              out_valid,
  input  logic              out_stall,
  output obm_pkg::status_t  status,
  output obm_pkg::price_t   trade_price,
  output obm_pkg::price_t   best_bid,
  output obm_pkg::price_t   best_ask
);
  import obm_pkg::*;

  logic       accept;
  logic       buy_match;
  logic       sell_match;
  book_cmd_t  bid_cmd;
  book_cmd_t  ask_cmd;
  book_stat_t bid_stat;
  book_stat_t ask_stat;
  status_t    status_next;
  price_t     trade_next;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  assign buy_match  = !ask_stat.empty && (ask_stat.head <= limit_price);
  assign sell_match = !bid_stat.empty && (bid_stat.head >= limit_price);

  always_comb begin
    bid_cmd.price = limit_price;
    ask_cmd.price = limit_price;
    bid_cmd.ins   = 1'b0;
    bid_cmd.pop   = 1'b0;
    ask_cmd.ins   = 1'b0;
    ask_cmd.pop   = 1'b0;
    status_next   = STATUS_DROP;
    trade_next    = '0;
    if (op == OP_BUY) begin
      if (buy_match) begin
        ask_cmd.pop = accept;
        status_next = STATUS_FILL;
        trade_next  = ask_stat.head;
      end else if (!bid_stat.full) begin
        bid_cmd.ins = accept;
        status_next = STATUS_REST;
      end
    end else begin
      if (sell_match) begin
        bid_cmd.pop = accept;
        status_next = STATUS_FILL;
        trade_next  = bid_stat.head;
      end else if (!ask_stat.full) begin
        ask_cmd.ins = accept;
        status_next = STATUS_REST;
      end
    end
  end

  obm_book #(
    .DEPTH (BOOK_DEPTH),
    .DESC  (1'b1)
  ) u_bid (
    .clk  (clk),
    .rst  (rst),
    .cmd  (bid_cmd),
    .stat (bid_stat)
  );

  obm_book #(
    .DEPTH (BOOK_DEPTH),
    .DESC  (1'b0)
  ) u_ask (
    .clk  (clk),
    .rst  (rst),
    .cmd  (ask_cmd),
    .stat (ask_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status      <= status_next;
      trade_price <= trade_next;
      best_bid    <= bid_stat.empty_next ? '0 : bid_stat.head_next;
      best_ask    <= ask_stat.empty_next ? '0 : ask_stat.head_next;
    end
  end

endmodule

// ----- design/obm_cell.sv -----
module obm_cell #(
  parameter int unsigned IDX  = 0,
  parameter int unsigned CW   = 7,
  parameter bit          DESC = 1'b1
) (
  input  logic                clk,
  input  obm_pkg::book_cmd_t  cmd,
  input  logic [CW-1:0]       count,
  input  logic                prev_hit,
  input  obm_pkg::price_t     prev_price,
  input  obm_pkg::price_t     next_price,
  output logic                hit,
  output obm_pkg::price_t     price,
  output obm_pkg::price_t     price_next
);
  import obm_pkg::*;

  localparam logic [CW-1:0] POS = CW'(IDX);

  logic occupied;
  logic cmp;

  assign occupied = count > POS;
  assign cmp      = DESC ? (cmd.price >= price) : (cmd.price <= price);
  assign hit      = !occupied || cmp;

  always_comb begin
    if (cmd.pop) begin
      price_next = next_price;
    end else if (cmd.ins && hit) begin
      price_next = prev_hit ? prev_price : cmd.price;
    end else begin
      price_next = price;
    end
  end

  always_ff @(posedge clk) begin
    price <= price_next;
  end

endmodule

// ----- design/obm_book.sv -----
module obm_book #(
  parameter int unsigned DEPTH = obm_pkg::OBM_BOOK_DEPTH,
  parameter bit          DESC  = 1'b1
) (
  input  logic                clk,
  input  logic                rst,
  input  obm_pkg::book_cmd_t  cmd,
  output obm_pkg::book_stat_t stat
);
  import obm_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic          hit      [DEPTH];
  price_t        price    [DEPTH];
  price_t        price_nx [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic   p_hit;
    price_t p_price;
    price_t n_price;

    if (i == 0) begin : g_first
      assign p_hit   = 1'b0;
      assign p_price = '0;
    end else begin : g_mid
      assign p_hit   = hit[i-1];
      assign p_price = price[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign n_price = price[i];
    end else begin : g_body
      assign n_price = price[i+1];
    end

    obm_cell #(
      .IDX  (i),
      .CW   (CW),
      .DESC (DESC)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .count      (count),
      .prev_hit   (p_hit),
      .prev_price (p_price),
      .next_price (n_price),
      .hit        (hit[i]),
      .price      (price[i]),
      .price_next (price_nx[i])
    );
  end

  always_comb begin
    if (cmd.pop) begin
      count_next = count - CW'(1);
    end else if (cmd.ins) begin
      count_next = count + CW'(1);
    end else begin
      count_next = count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  assign stat.head       = price[0];
  assign stat.head_next  = price_nx[0];
  assign stat.empty      = (count == '0);
  assign stat.empty_next = (count_next == '0);
  assign stat.full       = (count == CW'(DEPTH));

endmodule

// ----- design/obm_check.sv -----
module obm_check (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input obm_pkg::status_t  status,
  input obm_pkg::price_t   trade_price,
  input obm_pkg::price_t   best_bid,
  input obm_pkg::price_t   best_ask
);
  import obm_pkg::*;

  // held result keeps its payload
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(trade_price)
      && $stable(best_bid) && $stable(best_ask))
    else $error("held result changed");

  // every transfer in yields a result next cycle
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> out_valid)
    else $error("transfer produced no result");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> in_stall)
    else $error("input taken while result held");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && status != STATUS_FILL |-> trade_price == '0)
    else $error("trade price without a fill");

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status == STATUS_FILL || status == STATUS_REST || status == STATUS_DROP)
    else $error("bad status code");

endmodule

bind price_priority_order_book_match obm_check u_check (.*);

// ----- dv/tb_price_priority_order_book_match.sv -----
`timescale 1ns / 1ps

module tb_price_priority_order_book_match;
  import obm_pkg::*;

  localparam int DEPTH = OBM_BOOK_DEPTH;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    status_t st;
    price_t  trade;
    price_t  bid;
    price_t  ask;
  } book_result_t;

  typedef struct packed {
    logic         side;
    price_t       px;
    logic         known;
    book_result_t res;
  } order_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic op = OP_BUY;
  price_t limit_price = '0;
  logic out_stall = 1'b0;
  logic in_stall;
  logic out_valid;
  status_t status;
  price_t trade_price;
  price_t best_bid;
  price_t best_ask;

  price_t bid_levels [0:DEPTH-1];
  price_t ask_levels [0:DEPTH-1];
  int bid_n = 0;
  int ask_n = 0;

  book_result_t result_q [$];
  logic row_known = 1'b0;
  book_result_t row_res = '0;

  logic tx_idle = 1'b1;
  logic rx_idle = 1'b1;
  logic long_hold = 1'b0;

  int orders_n = 0;
  int fills_n = 0;
  int rests_n = 0;
  int drops_n = 0;
  int results_n = 0;
  int fail_n = 0;

  order_row_t dir_rows [0:25];

  price_priority_order_book_match uut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .op          (op),
    .limit_price (limit_price),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .trade_price (trade_price),
    .best_bid    (best_bid),
    .best_ask    (best_ask)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic book_result_t match_order(input logic side, input price_t px);
    book_result_t r;
    int pos;
    int i;
    r.st = STATUS_REST;
    r.trade = '0;
    if (side == OP_BUY) begin
      if (ask_n > 0 && ask_levels[0] <= px) begin
        r.st = STATUS_FILL;
        r.trade = ask_levels[0];
        for (i = 1; i < ask_n; i++) ask_levels[i-1] = ask_levels[i];
        ask_n--;
      end else if (bid_n >= DEPTH) begin
        r.st = STATUS_DROP;
      end else begin
        pos = 0;
        while (pos < bid_n && px < bid_levels[pos]) pos++;
        for (i = bid_n; i > pos; i--) bid_levels[i] = bid_levels[i-1];
        bid_levels[pos] = px;
        bid_n++;
      end
    end else begin
      if (bid_n > 0 && bid_levels[0] >= px) begin
        r.st = STATUS_FILL;
        r.trade = bid_levels[0];
        for (i = 1; i < bid_n; i++) bid_levels[i-1] = bid_levels[i];
        bid_n--;
      end else if (ask_n >= DEPTH) begin
        r.st = STATUS_DROP;
      end else begin
        pos = 0;
        while (pos < ask_n && px > ask_levels[pos]) pos++;
        for (i = ask_n; i > pos; i--) ask_levels[i] = ask_levels[i-1];
        ask_levels[pos] = px;
        ask_n++;
      end
    end
    r.bid = (bid_n > 0) ? bid_levels[0] : '0;
    r.ask = (ask_n > 0) ? ask_levels[0] : '0;
    return r;
  endfunction

  always @(posedge clk) begin : monitor
    book_result_t want;
    book_result_t got;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        want = match_order(op, limit_price);
        orders_n++;
        case (want.st)
          STATUS_FILL: fills_n++;
          STATUS_REST: rests_n++;
          default:     drops_n++;
        endcase
        result_q.insert(result_q.size(), row_known ? row_res : want);
      end
      if (out_valid && !out_stall) begin
        got = '{status, trade_price, best_bid, best_ask};
        results_n++;
        if (result_q.size() == 0) begin
          fail_n++;
          if (fail_n <= 10)
            $display("unexpected result: status=%0d trade=%0d bid=%0d ask=%0d",
                     got.st, got.trade, got.bid, got.ask);
        end else begin
          want = result_q.pop_front();
          if (got.st !== want.st || got.trade !== want.trade ||
              got.bid !== want.bid || got.ask !== want.ask) begin
            fail_n++;
            if (fail_n <= 10)
              $display("mismatch on result %0d: exp %0d/%0d/%0d/%0d act %0d/%0d/%0d/%0d",
                       results_n, want.st, want.trade, want.bid, want.ask,
                       got.st, got.trade, got.bid, got.ask);
          end
        end
      end
    end
  end

  initial begin : receiver
    int burst;
    burst = 0;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        long_hold = 1'b0;
        out_stall <= 1'b0;
      end else if (burst > 0) begin
        out_stall <= 1'b1;
        burst--;
      end else if (rx_idle && $urandom_range(0, 6) == 0) begin
        burst = $urandom_range(0, 11);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic place_order(input logic side, input price_t px, input logic known,
                             input book_result_t res);
    if (tx_idle && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    row_known = known;
    row_res = res;
    op <= side;
    limit_price <= px;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (result_q.size() != 0) @(negedge clk);
  endtask

  task automatic trade_band(input int count, input logic vary_idle, input int hold_at);
    int center;
    int i;
    center = 5000;
    for (i = 0; i < count; i++) begin
      if (i % 150 == 0) begin
        center = $urandom_range(200, 65335);
        if (vary_idle) begin
          tx_idle = 1'($urandom_range(0, 1));
          rx_idle = 1'($urandom_range(0, 1));
        end
      end
      if (i == hold_at) long_hold = 1'b1;
      place_order(1'($urandom_range(0, 1)),
                  price_t'(center - 200 + $urandom_range(0, 400)), 1'b0, '0);
    end
  endtask

  initial begin : stimulus
    int i;
    int start;
    dir_rows = '{
      '{OP_BUY,  16'd100,   1'b1, '{STATUS_REST, 16'd0,     16'd100,   16'd0}},
      '{OP_SELL, 16'd200,   1'b1, '{STATUS_REST, 16'd0,     16'd100,   16'd200}},
      '{OP_BUY,  16'd150,   1'b1, '{STATUS_REST, 16'd0,     16'd150,   16'd200}},
      '{OP_SELL, 16'd150,   1'b1, '{STATUS_FILL, 16'd150,   16'd100,   16'd200}},
      '{OP_BUY,  16'd200,   1'b1, '{STATUS_FILL, 16'd200,   16'd100,   16'd0}},
      '{OP_SELL, 16'd65535, 1'b1, '{STATUS_REST, 16'd0,     16'd100,   16'd65535}},
      '{OP_BUY,  16'd65535, 1'b1, '{STATUS_FILL, 16'd65535, 16'd100,   16'd0}},
      '{OP_BUY,  16'd65535, 1'b1, '{STATUS_REST, 16'd0,     16'd65535, 16'd0}},
      '{OP_SELL, 16'd1,     1'b1, '{STATUS_FILL, 16'd65535, 16'd100,   16'd0}},
      '{OP_SELL, 16'd0,     1'b1, '{STATUS_FILL, 16'd100,   16'd0,     16'd0}},
      '{OP_BUY,  16'd0,     1'b1, '{STATUS_REST, 16'd0,     16'd0,     16'd0}},
      '{OP_BUY,  16'd0,     1'b1, '{STATUS_REST, 16'd0,     16'd0,     16'd0}},
      '{OP_SELL, 16'd0,     1'b1, '{STATUS_FILL, 16'd0,     16'd0,     16'd0}},
      '{OP_SELL, 16'd1,     1'b1, '{STATUS_REST, 16'd0,     16'd0,     16'd1}},
      '{OP_BUY,  16'd0,     1'b1, '{STATUS_REST, 16'd0,     16'd0,     16'd1}},
      '{OP_SELL, 16'd0,     1'b1, '{STATUS_FILL, 16'd0,     16'd0,     16'd1}},
      '{OP_SELL, 16'd0,     1'b1, '{STATUS_FILL, 16'd0,     16'd0,     16'd1}},
      '{OP_SELL, 16'd0,     1'b1, '{STATUS_REST, 16'd0,     16'd0,     16'd0}},
      '{OP_BUY,  16'd0,     1'b1, '{STATUS_FILL, 16'd0,     16'd0,     16'd1}},
      '{OP_BUY,  16'd1,     1'b1, '{STATUS_FILL, 16'd1,     16'd0,     16'd0}},
      '{OP_BUY,  16'h8000,  1'b0, '0},
      '{OP_BUY,  16'h7fff,  1'b0, '0},
      '{OP_SELL, 16'h8001,  1'b0, '0},
      '{OP_SELL, 16'hfffe,  1'b0, '0},
      '{OP_BUY,  16'h5555,  1'b0, '0},
      '{OP_SELL, 16'haaaa,  1'b0, '0}
    };
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (i = 0; i < $size(dir_rows); i++)
      place_order(dir_rows[i].side, dir_rows[i].px, dir_rows[i].known, dir_rows[i].res);
    wait_drained();

    // trade around a moving mid, with one long receiver hold
    trade_band(700, 1'b1, 250);
    wait_drained();

    // fill the bid book past full, then the ask book
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    start = drops_n;
    i = 0;
    while (drops_n - start < 3 && i < 400) begin
      place_order(OP_BUY, price_t'($urandom_range(0, 300)), 1'b0, '0);
      i++;
    end
    start = drops_n;
    i = 0;
    while (drops_n - start < 3 && i < 400) begin
      place_order(OP_SELL, price_t'($urandom_range(60000, 65535)), 1'b0, '0);
      i++;
    end

    // full-range orders against both full books
    for (i = 0; i < 500; i++) begin
      if (i % 100 == 0) begin
        tx_idle = 1'($urandom_range(0, 1));
        rx_idle = 1'($urandom_range(0, 1));
      end
      place_order(1'($urandom_range(0, 1)), price_t'($urandom_range(0, 65535)), 1'b0, '0);
    end

    // no idling at the end
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    trade_band(450, 1'b0, -1);

    wait_drained();
    repeat (10) @(negedge clk);
    $display("%0d orders sent, %0d results checked: %0d fills, %0d rested, %0d dropped",
             orders_n, results_n, fills_n, rests_n, drops_n);
    $display("both books driven to full and drained with zero and extreme prices");
    if (fail_n == 0 && result_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule

// ----- filelist.f -----
design/obm_pkg.sv
design/obm_cell.sv
design/obm_book.sv
design/price_priority_order_book_match.sv
design/obm_check.sv
dv/tb_price_priority_order_book_match.sv
